>>> hw/rtl/upqv_pkg.sv
// ----------------------------------------------------------------------------
// upqv_pkg
// Types, character codes and byte classes for the request target validator.
// ----------------------------------------------------------------------------
`default_nettype none

package upqv_pkg;

  // verdict codes
  localparam logic [1:0] VERDICT_PENDING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd1;
  localparam logic [1:0] VERDICT_REJECT  = 2'd2;

  // character codes
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_DIG_0    = 8'h30;
  localparam logic [7:0] CH_DIG_9    = 8'h39;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_F     = 8'h46;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_F     = 8'h66;
  localparam logic [7:0] CH_LO_Z     = 8'h7A;

  localparam logic [1:0] HEX_DIGITS = 2'd2;

  typedef enum logic [2:0] {
    PH_SLASH = 3'b001,
    PH_PATH  = 3'b010,
    PH_QUERY = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       seg_nonempty;
    logic       part_nonempty;
    logic       in_value;
    logic [1:0] hex_pending;
    logic       failed;
  } upqv_state_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       done_res;
  } upqv_result_t;

  localparam upqv_state_t STATE_RESET = '{
    phase:         PH_SLASH,
    seg_nonempty:  1'b0,
    part_nonempty: 1'b0,
    in_value:      1'b0,
    hex_pending:   2'd0,
    failed:        1'b0
  };

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_LO_A && c <= CH_LO_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  function automatic logic in_segment_set(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_DOLLAR && c <= CH_DOT) ||
           c == CH_BANG || c == CH_COLON || c == CH_SEMI || c == CH_EQUAL ||
           c == CH_UNDER || c == CH_TILDE || c == CH_AT;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/upqv_if.sv
// ----------------------------------------------------------------------------
// upqv_if
// Valid/ready channels of the request target validator.
// ----------------------------------------------------------------------------
`default_nettype none

interface upqv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_target;

  modport source (output valid, output char_code, output end_of_target, input ready);
  modport sink   (input valid, input char_code, input end_of_target, output ready);
endinterface

interface upqv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       done_res;

  modport source (output valid, output verdict, output done_res, input ready);
  modport sink   (input valid, input verdict, input done_res, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/upqv_step.sv
// ----------------------------------------------------------------------------
// upqv_step
// Per-byte next state and verdict of the request target validator.
// ----------------------------------------------------------------------------
`default_nettype none

module upqv_step (
  input  upqv_pkg::upqv_state_t  state_cur,
  input  logic [7:0]             char_code,
  input  logic                   end_of_target,
  output upqv_pkg::upqv_state_t  state_nxt,
  output upqv_pkg::upqv_result_t result
);
  import upqv_pkg::*;

  upqv_state_t tk;
  logic        ok;

  // rules for one byte
  always_comb begin
    tk = state_cur;
    if (!state_cur.failed) begin
      if (state_cur.hex_pending != 2'd0) begin
        if (!is_hex(char_code)) begin
          tk.failed = 1'b1;
        end else begin
          tk.hex_pending = state_cur.hex_pending - 2'd1;
          if (state_cur.phase == PH_PATH) begin
            tk.seg_nonempty = 1'b1;
          end else begin
            tk.part_nonempty = 1'b1;
          end
        end
      end else begin
        case (state_cur.phase)
          PH_SLASH: begin
            if (char_code != CH_SLASH) begin
              tk.failed = 1'b1;
            end else begin
              tk.phase        = PH_PATH;
              tk.seg_nonempty = 1'b0;
            end
          end
          PH_PATH: begin
            if (char_code == CH_SLASH) begin
              if (!state_cur.seg_nonempty) tk.failed = 1'b1;
              tk.seg_nonempty = 1'b0;
            end else if (char_code == CH_PERCENT) begin
              tk.hex_pending = HEX_DIGITS;
            end else if (char_code == CH_QUESTION) begin
              tk.phase         = PH_QUERY;
              tk.part_nonempty = 1'b0;
              tk.in_value      = 1'b0;
            end else if (in_segment_set(char_code)) begin
              tk.seg_nonempty = 1'b1;
            end else begin
              tk.failed = 1'b1;
            end
          end
          PH_QUERY: begin
            if (char_code == CH_EQUAL) begin
              if (!state_cur.part_nonempty || state_cur.in_value) tk.failed = 1'b1;
              tk.part_nonempty = 1'b0;
              tk.in_value      = 1'b1;
            end else if (char_code == CH_AMP) begin
              if (!state_cur.part_nonempty || !state_cur.in_value) tk.failed = 1'b1;
              tk.part_nonempty = 1'b0;
              tk.in_value      = 1'b0;
            end else if (char_code == CH_PERCENT) begin
              tk.hex_pending = HEX_DIGITS;
            end else if (in_segment_set(char_code)) begin
              tk.part_nonempty = 1'b1;
            end else begin
              tk.failed = 1'b1;
            end
          end
          default: begin
            tk.failed = 1'b1;
          end
        endcase
      end
    end
  end

  // final verdict
  always_comb begin
    ok = !tk.failed && (tk.hex_pending == 2'd0);
    if (tk.phase == PH_QUERY) begin
      ok = ok && tk.in_value;
    end else if (tk.phase != PH_PATH) begin
      ok = 1'b0;
    end
  end

  always_comb begin
    if (end_of_target) begin
      state_nxt       = STATE_RESET;
      result.verdict  = ok ? VERDICT_ACCEPT : VERDICT_REJECT;
      result.done_res = 1'b1;
    end else begin
      state_nxt       = tk;
      result.verdict  = tk.failed ? VERDICT_REJECT : VERDICT_PENDING;
      result.done_res = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/uri_path_query_validator.sv
// ----------------------------------------------------------------------------
// uri_path_query_validator
// Byte-wise validator of an origin-form request target (path and query).
//
//   channel  dir  payload                      transfer
//   in_ch    in   char_code, end_of_target     valid && ready
//   out_ch   out  verdict, done_res            valid && ready
//
// one result per byte, registered through the input stage and then the output stage
// one byte per cycle sustained while out_ch is not stalled; the per-byte state update is combinational
// rst_n synchronous, clears the validator state and both stage valids
// a stalled output holds its result; the input stage still takes one byte
// ----------------------------------------------------------------------------
`default_nettype none

module uri_path_query_validator (
  input  logic              clk,
  input  logic              rst_n,
  upqv_in_if.sink           in_ch,
  upqv_out_if.source        out_ch
);
  import upqv_pkg::*;

  logic         in_v_r;
  logic [7:0]   char_r;
  logic         last_r;
  upqv_state_t  state_r;
  upqv_state_t  state_nxt;
  upqv_result_t res_nxt;
  upqv_result_t res_r;
  logic         out_v_r;
  logic         adv;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  upqv_step u_step (
    .state_cur     (state_r),
    .char_code     (char_r),
    .end_of_target (last_r),
    .state_nxt     (state_nxt),
    .result        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= STATE_RESET;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (adv) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r <= in_ch.char_code;
      last_r <= in_ch.end_of_target;
    end
    if (adv) res_r <= res_nxt;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.verdict  = res_r.verdict;
  assign out_ch.done_res = res_r.done_res;

`ifndef NO_ASSERTIONS
  a_hex_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hex_pending != 2'd3)
    else $error("hex digit count out of range");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_r.failed && !last_r |=> state_r.failed)
    else $error("failure flag cleared inside a target");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> state_r == STATE_RESET)
    else $error("state not cleared after final byte");

  a_done_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.done_res |-> res_r.verdict != VERDICT_PENDING)
    else $error("final result without verdict");

  a_fail_reported: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_r.failed |=> res_r.verdict == VERDICT_REJECT)
    else $error("failed target not reported as rejected");
`endif

endmodule

`default_nettype wire

>>> dv/uri_path_query_validator_tb.sv
// ----------------------------------------------------------------------------
// uri_path_query_validator_tb
// Byte-level check of the request target validator. Directed targets cover
// the syntax rules and illegal bytes, then random well-formed, corrupted and
// noise targets run under random source gaps and sink stalls. A per-byte
// predictor keeps its own parse state and checks every verdict in order.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_path_query_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import upqv_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  upqv_in_if  in_ch ();
  upqv_out_if out_ch ();

  uri_path_query_validator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor parse state
  phase_t     tgt_phase;
  logic       tgt_seg_filled;
  logic       tgt_part_filled;
  logic       tgt_in_value;
  logic [1:0] tgt_hex_left;
  logic       tgt_broken;

  upqv_result_t verdict_q[$];

  bit          sender_calm = 1'b0;
  bit          sink_calm   = 1'b0;
  int unsigned sink_hold   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned targets_sent = 0;
  int unsigned results_seen = 0;
  int unsigned accepted    = 0;
  int unsigned rejected    = 0;
  int unsigned mismatches  = 0;

  function automatic bit is_hex_byte(input logic [7:0] c);
    return c inside {[CH_DIG_0:CH_DIG_9], [CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]};
  endfunction

  function automatic bit is_pchar(input logic [7:0] c);
    return c inside {[CH_DIG_0:CH_DIG_9], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                     [CH_DOLLAR:CH_DOT], CH_BANG, CH_COLON, CH_SEMI, CH_EQUAL,
                     CH_UNDER, CH_TILDE, CH_AT};
  endfunction

  function automatic void clear_target_state();
    tgt_phase       = PH_SLASH;
    tgt_seg_filled  = 1'b0;
    tgt_part_filled = 1'b0;
    tgt_in_value    = 1'b0;
    tgt_hex_left    = 2'd0;
    tgt_broken      = 1'b0;
  endfunction

  function automatic upqv_result_t predict_result(input logic [7:0] c, input logic last);
    upqv_result_t r;
    logic ok;
    if (!tgt_broken) begin
      if (tgt_hex_left != 2'd0) begin
        if (!is_hex_byte(c)) begin
          tgt_broken = 1'b1;
        end else begin
          tgt_hex_left = tgt_hex_left - 2'd1;
          if (tgt_phase == PH_PATH) tgt_seg_filled = 1'b1;
          else tgt_part_filled = 1'b1;
        end
      end else begin
        case (tgt_phase)
          PH_SLASH: begin
            if (c == CH_SLASH) begin
              tgt_phase = PH_PATH;
              tgt_seg_filled = 1'b0;
            end else begin
              tgt_broken = 1'b1;
            end
          end
          PH_PATH: begin
            if (c == CH_SLASH) begin
              if (!tgt_seg_filled) tgt_broken = 1'b1;
              tgt_seg_filled = 1'b0;
            end else if (c == CH_PERCENT) begin
              tgt_hex_left = HEX_DIGITS;
            end else if (c == CH_QUESTION) begin
              tgt_phase = PH_QUERY;
              tgt_part_filled = 1'b0;
              tgt_in_value = 1'b0;
            end else if (is_pchar(c)) begin
              tgt_seg_filled = 1'b1;
            end else begin
              tgt_broken = 1'b1;
            end
          end
          PH_QUERY: begin
            if (c == CH_EQUAL) begin
              if (!tgt_part_filled || tgt_in_value) tgt_broken = 1'b1;
              tgt_part_filled = 1'b0;
              tgt_in_value = 1'b1;
            end else if (c == CH_AMP) begin
              if (!tgt_part_filled || !tgt_in_value) tgt_broken = 1'b1;
              tgt_part_filled = 1'b0;
              tgt_in_value = 1'b0;
            end else if (c == CH_PERCENT) begin
              tgt_hex_left = HEX_DIGITS;
            end else if (is_pchar(c)) begin
              tgt_part_filled = 1'b1;
            end else begin
              tgt_broken = 1'b1;
            end
          end
          default: begin
            tgt_broken = 1'b1;
          end
        endcase
      end
    end
    if (!last) begin
      r.verdict  = tgt_broken ? VERDICT_REJECT : VERDICT_PENDING;
      r.done_res = 1'b0;
    end else begin
      ok = !tgt_broken && tgt_hex_left == 2'd0;
      if (ok) begin
        if (tgt_phase == PH_QUERY) ok = tgt_in_value;
        else if (tgt_phase != PH_PATH) ok = 1'b0;
      end
      r.verdict  = ok ? VERDICT_ACCEPT : VERDICT_REJECT;
      r.done_res = 1'b1;
      clear_target_state();
    end
    return r;
  endfunction

  function automatic int unsigned pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = pick_wait(sender_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_code     <= c;
    in_ch.end_of_target <= last;
    do @(posedge clk); while (!in_ch.ready);
    verdict_q.push_back(predict_result(c, last));
    bytes_sent++;
  endtask

  task automatic send_target(input logic [7:0] t[$]);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
    targets_sent++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_content(ref logic [7:0] t[$], input bit query, input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        t.push_back(CH_PERCENT);
        repeat (2) begin
          do c = 8'($urandom_range(CH_DIG_0, CH_LO_F)); while (!is_hex_byte(c));
          t.push_back(c);
        end
      end else begin
        do c = 8'($urandom_range(CH_BANG, CH_TILDE));
        while (!is_pchar(c) || c == CH_PERCENT ||
               (query && (c == CH_EQUAL || c == CH_AMP)));
        t.push_back(c);
      end
    end
  endtask

  task automatic make_random_target(ref logic [7:0] t[$]);
    int unsigned kind;
    int unsigned nseg;
    int unsigned nparts;
    kind = $urandom_range(0, 9);
    t.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      t.push_back(CH_SLASH);
      nseg = $urandom_range(0, 3);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) t.push_back(CH_SLASH);
        add_content(t, 1'b0, $urandom_range(1, 4));
      end
      if (nseg > 0 && $urandom_range(0, 3) == 0) t.push_back(CH_SLASH);
      if ($urandom_range(0, 1) == 1) begin
        t.push_back(CH_QUESTION);
        nparts = $urandom_range(1, 3);
        for (int p = 0; p < nparts; p++) begin
          if (p > 0) t.push_back(CH_AMP);
          add_content(t, 1'b1, $urandom_range(1, 3));
          t.push_back(CH_EQUAL);
          add_content(t, 1'b1, (p == nparts - 1) ? $urandom_range(0, 3) : $urandom_range(1, 3));
        end
      end
      // broken variants
      if (kind == 1) begin
        t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 2) begin
        t = t[0:$urandom_range(0, t.size() - 1)];
      end else if (kind == 3) begin
        t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_well_formed();
    send_target('{CH_SLASH, CH_PERCENT, "a", "F", CH_QUESTION, "k", CH_EQUAL});
    wait_all_results();
  endtask

  task automatic test_path_rules();
    send_target('{CH_SLASH, "a", CH_SLASH});
    send_target('{CH_SLASH, CH_SLASH});
    wait_all_results();
  endtask

  task automatic test_query_edges();
    send_target('{CH_SLASH, CH_QUESTION});
    send_target('{CH_SLASH, CH_QUESTION, "a", CH_SLASH});
    wait_all_results();
  endtask

  task automatic test_percent_escapes();
    send_target('{CH_SLASH, CH_PERCENT, "4"});
    wait_all_results();
  endtask

  task automatic test_illegal_bytes();
    send_target('{8'hFF});
    send_target('{CH_SLASH, 8'h00, "a", "b"});
    wait_all_results();
  endtask

  task automatic test_backpressure();
    logic [7:0] t[$];
    int unsigned start;
    start = bytes_sent;
    sender_calm = 1'b1;
    sink_hold = 80;
    while (bytes_sent - start < 40) begin
      make_random_target(t);
      send_target(t);
    end
    sender_calm = 1'b0;
    wait_all_results();
  endtask

  task automatic test_drain_pause();
    logic [7:0] t[$];
    repeat (3) begin
      make_random_target(t);
      send_target(t);
      wait_all_results();
    end
  endtask

  task automatic test_random_targets();
    logic [7:0] t[$];
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < 500) begin
      if ($urandom_range(0, 7) == 0) begin
        sender_calm = ($urandom_range(0, 2) == 0);
        sink_calm   = ($urandom_range(0, 2) == 0);
      end
      make_random_target(t);
      send_target(t);
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
    wait_all_results();
  endtask

  // result sink with random stalls and an occasional long hold-off
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold != 0) begin
        stall = sink_hold;
        sink_hold = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stall = pick_wait(sink_calm);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : verdict_checker
    upqv_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transfer verdict=%0d done_res=%0b", $realtime,
                   out_ch.verdict, out_ch.done_res);
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.verdict !== want.verdict || out_ch.done_res !== want.done_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch verdict exp %0d got %0d, done_res exp %0b got %0b",
                     $realtime, want.verdict, out_ch.verdict, want.done_res,
                     out_ch.done_res);
        end
        if (want.done_res && want.verdict == VERDICT_ACCEPT) accepted++;
        if (want.done_res && want.verdict == VERDICT_REJECT) rejected++;
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.char_code     <= 8'h00;
    in_ch.end_of_target <= 1'b0;
    clear_target_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_well_formed();
    test_path_rules();
    test_query_edges();
    test_percent_escapes();
    test_illegal_bytes();
    test_backpressure();
    test_drain_pause();
    test_random_targets();

    wait_all_results();
    repeat (8) @(posedge clk);

    if (verdict_q.size() != 0) $display("%0d expected results never arrived", verdict_q.size());
    $display("%0d bytes in %0d targets checked, %0d accepted and %0d rejected",
             results_seen, targets_sent, accepted, rejected);
    $display("covered path and query syntax, escapes, illegal bytes, long sink stall, pauses");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/upqv_pkg.sv
hw/rtl/upqv_if.sv
hw/rtl/upqv_step.sv
hw/rtl/uri_path_query_validator.sv
dv/uri_path_query_validator_tb.sv
